/* src/pcic_pkg.sv */
// ----------------------------------------------------------------------------
// pcic_pkg: shared types and constants for the PDM CIC decimator
// Holds the field widths, the default word length, the per-bit weight
// functions and the record passed from the word stage to the filter core.
// ----------------------------------------------------------------------------
`default_nettype none

package pcic_pkg;

  // Field widths of the stream payloads.
  localparam int WORD_W   = 16;
  localparam int SAMPLE_W = 16;
  // All filter arithmetic wraps at this width.
  localparam int ACC_W    = 16;

  // Default number of PDM bits in one input word (decimation ratio).
  localparam int BITS_PER_WORD_DEF = 16;

  // Per-word contributions of the bits to the three integrators. Each value
  // is already the signed sum over all bits of the word (a one bit counts
  // +1, a zero bit counts -1), reduced modulo two to the sixteenth.
  typedef struct packed {
    logic             first;
    logic [ACC_W-1:0] s1;
    logic [ACC_W-1:0] s2;
    logic [ACC_W-1:0] s3;
  } pcic_word_t;

  // Weight of a bit at position pos in the second integrator: the number of
  // second-integrator updates that still see it, which is pos + 1.
  function automatic logic [ACC_W-1:0] pcic_weight2(input int pos);
    int w;
    w = pos + 1;
    return ACC_W'(w);
  endfunction

  // Weight of a bit at position pos in the third integrator: the triangular
  // number of pos + 1.
  function automatic logic [ACC_W-1:0] pcic_weight3(input int pos);
    int w;
    w = ((pos + 1) * (pos + 2)) / 2;
    return ACC_W'(w);
  endfunction

endpackage

`default_nettype wire

/* src/pcic_word.sv */
// ----------------------------------------------------------------------------
// pcic_word: input register stage of the PDM CIC decimator
// Accepts one PDM word, reduces its bits to the three per-word integrator
// contributions and holds them in a register until the core takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module pcic_word #(
  parameter int BITS_PER_WORD = pcic_pkg::BITS_PER_WORD_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [pcic_pkg::WORD_W-1:0] s_axis_tdata,
  input  wire logic                       s_axis_tuser,
  input  wire logic                       take,
  output logic                            word_valid,
  output pcic_pkg::pcic_word_t            word
);
  import pcic_pkg::*;

  // Bits above the 16-bit field read as zero, so only these positions can
  // contribute a one.
  localparam int NUM_USED = (BITS_PER_WORD < WORD_W) ? BITS_PER_WORD : WORD_W;
  // Sums of the weights over every bit of the word (all bits at -1).
  localparam logic [ACC_W-1:0] N_C = ACC_W'(BITS_PER_WORD);
  localparam logic [ACC_W-1:0] K_C = ACC_W'((BITS_PER_WORD * (BITS_PER_WORD + 1)) / 2);
  localparam logic [ACC_W-1:0] L_C =
    ACC_W'((BITS_PER_WORD * (BITS_PER_WORD + 1) * (BITS_PER_WORD + 2)) / 6);

  logic             load;
  logic [ACC_W-1:0] ones;
  logic [ACC_W-1:0] b2;
  logic [ACC_W-1:0] b3;
  pcic_word_t       word_next;

  // The register frees up when empty or when the core takes its item.
  assign s_axis_tready = !word_valid || take;
  assign load          = s_axis_tvalid && s_axis_tready;

  // Weighted counts of the one bits; constant weights, so this is an adder tree.
  always_comb begin
    ones = '0;
    b2   = '0;
    b3   = '0;
    for (int p = 0; p < NUM_USED; p++) begin
      if (s_axis_tdata[p]) begin
        ones = ones + ACC_W'(1);
        b2   = b2 + pcic_weight2(p);
        b3   = b3 + pcic_weight3(p);
      end
    end
  end

  // Each one bit counts twice its weight against the all-minus-one baseline.
  always_comb begin
    word_next.first = s_axis_tuser;
    word_next.s1    = (ones << 1) - N_C;
    word_next.s2    = (b2 << 1) - K_C;
    word_next.s3    = (b3 << 1) - L_C;
  end

  // Valid flag of the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (load) begin
      word_valid <= 1'b1;
    end else if (take) begin
      word_valid <= 1'b0;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      word <= word_next;
    end
  end

  // A held item stays until the core takes it.
  a_hold_until_taken: assert property (@(posedge clk) disable iff (rst)
    (word_valid && !take) |=> word_valid)
    else $error("word stage dropped an item that was not taken");

  // Taking an item needs one to be there.
  a_take_needs_item: assert property (@(posedge clk) disable iff (rst)
    take |-> word_valid)
    else $error("core took from an empty word stage");

  // A one-bit count can never exceed the bits in use.
  a_ones_range: assert property (@(posedge clk) disable iff (rst)
    ones <= ACC_W'(NUM_USED))
    else $error("bit count out of range");

endmodule

`default_nettype wire

/* src/pcic_core.sv */
// ----------------------------------------------------------------------------
// pcic_core: integrator cascade, comb stages and result register
// Advances the three integrators by one whole word in closed form, runs the
// three comb stages and registers the PCM sample for the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module pcic_core #(
  parameter int BITS_PER_WORD = pcic_pkg::BITS_PER_WORD_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          word_valid,
  input  wire pcic_pkg::pcic_word_t          word,
  output logic                               take,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [pcic_pkg::SAMPLE_W-1:0]      m_axis_tdata
);
  import pcic_pkg::*;

  // A word of N bits moves the second integrator by N times the first and the
  // third by N times the second plus N(N+1)/2 times the first.
  localparam logic [ACC_W-1:0] N_C = ACC_W'(BITS_PER_WORD);
  localparam logic [ACC_W-1:0] K_C = ACC_W'((BITS_PER_WORD * (BITS_PER_WORD + 1)) / 2);

  logic [ACC_W-1:0] integ_one;
  logic [ACC_W-1:0] integ_two;
  logic [ACC_W-1:0] integ_three;
  logic [ACC_W-1:0] comb_one_prev;
  logic [ACC_W-1:0] comb_two_prev;

  logic [ACC_W-1:0] i1_cur;
  logic [ACC_W-1:0] i2_cur;
  logic [ACC_W-1:0] i3_cur;
  logic [ACC_W-1:0] cp1_cur;
  logic [ACC_W-1:0] cp2_cur;
  logic [ACC_W-1:0] integ_one_next;
  logic [ACC_W-1:0] integ_two_next;
  logic [ACC_W-1:0] integ_three_next;
  logic [ACC_W-1:0] c1;
  logic [ACC_W-1:0] c2;
  logic [ACC_W-1:0] c3;

  // Take a word whenever the result register is empty or being emptied.
  assign take = word_valid && (!m_axis_tvalid || m_axis_tready);

  // A first word starts from cleared state.
  always_comb begin
    i1_cur  = word.first ? '0 : integ_one;
    i2_cur  = word.first ? '0 : integ_two;
    i3_cur  = word.first ? '0 : integ_three;
    cp1_cur = word.first ? '0 : comb_one_prev;
    cp2_cur = word.first ? '0 : comb_two_prev;
  end

  // Whole-word integrator update; the first comb output is the third
  // integrator's growth over the word.
  always_comb begin
    integ_one_next   = i1_cur + word.s1;
    integ_two_next   = i2_cur + ACC_W'(N_C * i1_cur) + word.s2;
    c1               = ACC_W'(N_C * i2_cur) + ACC_W'(K_C * i1_cur) + word.s3;
    integ_three_next = i3_cur + c1;
    c2               = c1 - cp1_cur;
    c3               = c2 - cp2_cur;
  end

  // Filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      integ_one     <= '0;
      integ_two     <= '0;
      integ_three   <= '0;
      comb_one_prev <= '0;
      comb_two_prev <= '0;
    end else if (take) begin
      integ_one     <= integ_one_next;
      integ_two     <= integ_two_next;
      integ_three   <= integ_three_next;
      comb_one_prev <= c1;
      comb_two_prev <= c2;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (take) begin
      m_axis_tdata <= SAMPLE_W'(c3);
    end
  end

  // Every word taken shows up as a result in the next cycle.
  a_take_gives_result: assert property (@(posedge clk) disable iff (rst)
    take |=> m_axis_tvalid)
    else $error("taken word produced no result");

  // A first word sees cleared comb delays, so its first comb output is its
  // own third-integrator contribution.
  a_first_clears: assert property (@(posedge clk) disable iff (rst)
    (take && word.first) |=> (comb_one_prev == $past(word.s3)))
    else $error("first word did not start from cleared state");

  // State only moves when a word is taken.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !take |=> ($stable(integ_one) && $stable(integ_three) && $stable(comb_two_prev)))
    else $error("filter state changed without a word");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result pending after reset");

endmodule

`default_nettype wire

/* src/pdm_cic_decimator.sv */
// ----------------------------------------------------------------------------
// pdm_cic_decimator: third-order CIC decimator for PDM audio
// Turns each word of PDM bits (MSB earliest) into one signed 16-bit PCM
// sample through three integrators and three one-word comb stages.
//
//   Channel  Direction  Payload                          Sideband
//   s_axis   in         tdata[15:0] = pdm_word           tuser = first_word
//   m_axis   out        tdata[15:0] = pcm_sample         none
//
// One word is accepted per cycle while the output is not stalled; the word register
// captures it at the accepting edge and the result register takes its sample when the
// core takes the word. The per-word bit sums in the word register and the closed-form
// integrator update in the core set the cycle path; the state loop runs through the state registers.
// Reset (rst, synchronous) clears the filter state and both valid flags.
// A stalled output holds its sample while one more word can still be accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module pdm_cic_decimator #(
  parameter int BITS_PER_WORD = pcic_pkg::BITS_PER_WORD_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [pcic_pkg::WORD_W-1:0]   s_axis_tdata,  // [15:0] pdm_word
  input  wire logic                          s_axis_tuser,  // [0] first_word
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [pcic_pkg::SAMPLE_W-1:0]      m_axis_tdata   // [15:0] pcm_sample
);
  import pcic_pkg::*;

  logic       take;
  logic       word_valid;
  pcic_word_t word;

  // Word stage: bit sums per accepted word.
  pcic_word #(
    .BITS_PER_WORD(BITS_PER_WORD)
  ) u_word (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .take          (take),
    .word_valid    (word_valid),
    .word          (word)
  );

  // Filter core: integrators, combs and result register.
  pcic_core #(
    .BITS_PER_WORD(BITS_PER_WORD)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .word_valid    (word_valid),
    .word          (word),
    .take          (take),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

/* bench/pcic_checker.sv */
// ----------------------------------------------------------------------------
// pcic_checker: scoreboard for the PDM CIC decimator
// Watches both stream channels. Every accepted PDM word is run through a
// bit-serial model of the third-order integrator cascade and comb stages, and
// the predicted PCM sample is queued. Every accepted output sample is compared
// with the oldest queued prediction.
// ----------------------------------------------------------------------------
module pcic_checker
  import pcic_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [WORD_W-1:0]   s_tdata,   // [15:0] pdm_word
  input  logic                s_tuser,   // [0] first_word
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [SAMPLE_W-1:0] m_tdata,   // [15:0] pcm_sample
  output int                  mismatches,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Filter state of the predictor; all arithmetic wraps at ACC_W bits.
  logic [ACC_W-1:0] integ_a;
  logic [ACC_W-1:0] integ_b;
  logic [ACC_W-1:0] integ_c;
  logic [ACC_W-1:0] comb_a_prev;
  logic [ACC_W-1:0] comb_b_prev;

  // Samples predicted but not yet seen on the output.
  logic [SAMPLE_W-1:0] samples_due[$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic void clear_filter();
    integ_a     = '0;
    integ_b     = '0;
    integ_c     = '0;
    comb_a_prev = '0;
    comb_b_prev = '0;
  endfunction

  // Runs one PDM word through the integrators bit by bit, MSB first, then
  // through the three comb stages, and returns the decimated sample.
  function automatic logic [SAMPLE_W-1:0] decimate_word(input logic [WORD_W-1:0] bits_in,
                                                        input logic clear);
    logic [ACC_W-1:0] held_c;
    logic [ACC_W-1:0] diff_a;
    logic [ACC_W-1:0] diff_b;
    logic [ACC_W-1:0] diff_c;
    int pos;
    if (clear) begin
      clear_filter();
    end
    held_c = integ_c;
    for (pos = BITS_PER_WORD_DEF - 1; pos >= 0; pos--) begin
      if (bits_in[pos]) begin
        integ_a = integ_a + 1'b1;
      end else begin
        integ_a = integ_a - 1'b1;
      end
      integ_b = integ_b + integ_a;
      integ_c = integ_c + integ_b;
    end
    diff_a = integ_c - held_c;
    diff_b = diff_a - comb_a_prev;
    diff_c = diff_b - comb_b_prev;
    comb_a_prev = diff_a;
    comb_b_prev = diff_b;
    return diff_c;
  endfunction

  task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] want,
                                 input logic [SAMPLE_W-1:0] got);
    $display("[%0t] mismatch: %s, expected %0d, got %0d",
             $realtime, what, $signed(want), $signed(got));
    mismatches++;
  endtask

  // Both channels are sampled at the rising edge, where a transaction completes.
  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] want;
    if (rst) begin
      clear_filter();
      samples_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (samples_due.size() == 0) begin
          report_mismatch("pcm_sample with no word pending", '0, m_tdata);
        end else begin
          want = samples_due.pop_front();
          if (m_tdata !== want) begin
            report_mismatch("pcm_sample", want, m_tdata);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        samples_due.push_back(decimate_word(s_tdata, s_tuser));
      end
    end
    pending <= samples_due.size();
  end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the PDM CIC decimator
// Feeds directed corner words and then random PDM streams, each usually
// opened by a first word, with random gaps on the input and random stalls
// on the output, including one long output stall that backs up the block.
// Checking is done by pcic_checker alongside the design.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pcic_pkg::*;

  localparam int RANDOM_WORDS = 1400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_AT      = 600;
  localparam int HOLD_LEN     = 250;
  localparam int TAIL_CYCLES  = 8;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [WORD_W-1:0]   s_axis_tdata;   // [15:0] pdm_word
  logic                s_axis_tuser;   // [0] first_word
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [SAMPLE_W-1:0] m_axis_tdata;   // [15:0] pcm_sample

  int errors;
  int pending;
  int cycles = 0;
  bit burst_mode = 1'b0;

  always #4 clk = ~clk;

  pdm_cic_decimator u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  pcic_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_axis_tvalid),
    .s_tready   (s_axis_tready),
    .s_tdata    (s_axis_tdata),
    .s_tuser    (s_axis_tuser),
    .m_tvalid   (m_axis_tvalid),
    .m_tready   (m_axis_tready),
    .m_tdata    (m_axis_tdata),
    .mismatches (errors),
    .pending    (pending)
  );

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Idle cycles before the next word: mostly none or short, a few long.
  function automatic int pick_gap();
    int r;
    if (burst_mode) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Word whose bits are ones with a probability of density/16.
  function automatic logic [WORD_W-1:0] pdm_bits(input int density);
    logic [WORD_W-1:0] w;
    for (int i = 0; i < WORD_W; i++) begin
      w[i] = ($urandom_range(0, 15) < density);
    end
    return w;
  endfunction

  // Offers one word, starting and ending at a falling edge, until it is taken.
  task automatic send_word(input logic [WORD_W-1:0] word, input logic first);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= first;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Output side: random stalls, steady stretches and one long hold-off.
  initial begin
    int rx_cycles;
    int stall_left;
    int r;
    bit steady;
    rx_cycles  = 0;
    stall_left = 0;
    steady     = 1'b0;
    m_axis_tready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      rx_cycles++;
      if (rx_cycles % 256 == 0) begin
        steady = ($urandom_range(0, 3) == 0);
      end
      if (rx_cycles == HOLD_AT) begin
        stall_left = HOLD_LEN;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (steady) begin
        m_axis_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(6, 30);
        end
      end
    end
  end

  // Input side and verdict.
  initial begin
    int sent;
    int run_len;
    int density;
    int kind;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: starting with no first word, then the extremes and patterns.
    send_word(16'h0000, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'h0001, 1'b0);
    send_word(16'hAAAA, 1'b0);
    send_word(16'h5555, 1'b0);
    send_word(16'h7FFF, 1'b0);
    send_word(16'hFFFE, 1'b0);
    // Full-scale positive run, long enough for the integrators to wrap.
    send_word(16'hFFFF, 1'b1);
    repeat (5) send_word(16'hFFFF, 1'b0);
    // Full-scale negative run.
    send_word(16'h0000, 1'b1);
    repeat (3) send_word(16'h0000, 1'b0);
    send_word(16'h00FF, 1'b1);
    send_word(16'hFF00, 1'b0);
    send_word(16'h0F0F, 1'b0);
    send_word(16'h8001, 1'b1);
    send_word(16'h8001, 1'b1);

    // Random: mostly streams opened by a first word, some loose words.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      kind = $urandom_range(0, 9);
      burst_mode = ($urandom_range(0, 5) == 0);
      if (kind == 0) begin
        send_word(WORD_W'($urandom), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        run_len = $urandom_range(4, 48);
        density = $urandom_range(0, 16);
        send_word(pdm_bits(density), (kind != 1));
        for (int i = 1; i < run_len; i++) begin
          if (kind == 2) begin
            send_word(WORD_W'($urandom), 1'b0);
          end else begin
            send_word(pdm_bits(density), 1'b0);
          end
        end
        sent += run_len;
      end
    end
    s_axis_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
